// File: design/swma_pkg.sv
// Package for the sliding window moving average block.
// Holds the sequencer state type, control structs and fixed register constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swma_pkg;

  // The window length register has a fixed width.
  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 9'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } seq_state_e;

  // Sequencer to window: one strobe per phase of an item.
  typedef struct packed {
    logic accept;  // Write the new sample and read the oldest one.
    logic update;  // Commit the new sum, count and pointers.
    logic last;    // The item closes its stream; empty the window on update.
    logic clear;   // A register write empties the window.
  } win_ctrl_t;

  // Sequencer to divider.
  typedef struct packed {
    logic start;
    logic ack;
  } div_ctrl_t;

  // Divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: design/swma_if.sv
// Channel interfaces of the moving average block: input, result and config.
// Each carries valid, ready and the payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface swma_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface swma_out_if #(
  parameter int unsigned AVERAGE_BITS = 24,
  parameter int unsigned FILL_BITS    = 9
) ();
  logic                           valid;
  logic                           ready;
  logic signed [AVERAGE_BITS-1:0] average;
  logic        [FILL_BITS-1:0]    fill_count;
  logic                           last_result;

  modport source (output valid, output average, output fill_count, output last_result,
                  input ready);
  modport sink   (input valid, input average, input fill_count, input last_result,
                  output ready);
endinterface

interface swma_cfg_if ();
  logic       valid;
  logic       ready;
  logic [8:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// File: design/sliding_window_moving_average.sv
// Top level of the sliding window moving average block.
// Depends on swma_pkg, the channel interfaces, swma_window and swma_divider.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// in_i      sink       sample, end_of_stream
// out_o     source     average, fill_count, last_result
// cfg_i     sink       window_length
//
// An item is taken only while the sequencer is idle. In the update state the window
// commits the new sum and count and the restoring divider starts; it produces one
// quotient bit per cycle over SAMPLE_BITS + clog2(MAX_WINDOW) + FRACTION_BITS bits
// (32 by default), then the result register is loaded. The next item is taken
// only after the result register has been loaded.
// Reset is asynchronous and empties the window; the window length returns to 8.
// The store needs no clearing pass. A stalled result register holds the divider
// until it frees up; input and config are refused while an item is in flight.

module sliding_window_moving_average
  import swma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW    = 256,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  swma_in_if.sink      in_i,
  swma_out_if.source   out_o,
  swma_cfg_if.sink     cfg_i
);

  // Derived widths: fill count, running sum, divider dividend and result.
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned DVD_W = SUM_W + FRACTION_BITS;
  localparam int unsigned AVG_W = SAMPLE_BITS + FRACTION_BITS;

  seq_state_e state_q, state_d;

  logic [CFG_W-1:0] len_q;
  logic [CNT_W-1:0] eff_len;

  logic                    last_q;
  logic                    cfg_fire;
  logic                    in_fire;
  logic                    load_out;

  win_ctrl_t               win_ctrl;
  logic signed [SUM_W-1:0] new_sum;
  logic        [CNT_W-1:0] new_count;

  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic        [SUM_W-1:0] sum_mag;
  logic        [DVD_W-1:0] dividend;
  logic signed [AVG_W-1:0] quotient;

  logic                    out_valid_q;
  logic signed [AVG_W-1:0] avg_q;
  logic        [CNT_W-1:0] fill_q;
  logic        [CNT_W-1:0] fill_res_q;
  logic                    last_out_q;

  // A length of zero acts as one; lengths above the store depth are clamped.
  always_comb begin
    if (32'(len_q) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else if (len_q == '0) begin
      eff_len = CNT_W'(1);
    end else begin
      eff_len = CNT_W'(len_q);
    end
  end

  // Config writes and items are both taken only when idle; a pending config
  // write goes first so that the window is emptied before the next item.
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  // The result register is loaded once the quotient is ready and the slot is free.
  assign load_out = (state_q == ST_DIVIDE) && div_stat.done && (!out_valid_q || out_o.ready);

  // The sum magnitude is scaled by the fraction bits before division.
  assign sum_mag  = new_sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(new_sum)) : SUM_W'(new_sum);
  assign dividend = DVD_W'(sum_mag) << FRACTION_BITS;

  always_comb begin
    state_d         = state_q;
    win_ctrl.accept = 1'b0;
    win_ctrl.update = 1'b0;
    win_ctrl.last   = last_q;
    win_ctrl.clear  = cfg_fire;
    div_ctrl.start  = 1'b0;
    div_ctrl.ack    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          win_ctrl.accept = 1'b1;
          state_d         = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        win_ctrl.update = 1'b1;
        div_ctrl.start  = 1'b1;
        state_d         = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (load_out) begin
          div_ctrl.ack = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= WINDOW_LENGTH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        len_q <= cfg_i.window_length;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_q <= in_i.end_of_stream;
    end
    if (state_q == ST_UPDATE) begin
      fill_res_q <= new_count;
    end
    if (load_out) begin
      avg_q      <= quotient;
      fill_q     <= fill_res_q;
      last_out_q <= last_q;
    end
  end

  swma_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (win_ctrl),
    .sample_i    (in_i.sample),
    .eff_len_i   (eff_len),
    .new_sum_o   (new_sum),
    .new_count_o (new_count)
  );

  swma_divider #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W),
    .RES_W (AVG_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (new_count),
    .neg_i      (new_sum[SUM_W-1]),
    .stat_o     (div_stat),
    .result_o   (quotient)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.average     = avg_q;
  assign out_o.fill_count  = fill_q;
  assign out_o.last_result = last_out_q;

endmodule

`default_nettype wire

// File: design/swma_window.sv
// Ring store of samples with running sum, fill count and pointers.
// Depends on swma_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module swma_window
  import swma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 9,
  parameter int unsigned SUM_W       = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  win_ctrl_t                    ctrl_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  input  wire        [CNT_W-1:0]       eff_len_i,
  output logic signed [SUM_W-1:0]      new_sum_o,
  output logic       [CNT_W-1:0]       new_count_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] evict_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          evict_flag_q, evict_flag_d;

  logic [PTR_W-1:0]        old_ptr_q, old_ptr_d;
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] evict_ext;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(MAX_WINDOW - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Read comes before write, so a full ring of MAX_WINDOW entries sees the old sample.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      evict_q              <= store_mem[old_ptr_q];
      store_mem[wr_ptr_q]  <= sample_i;
      sample_q             <= sample_i;
    end
  end

  assign evict_flag_d = (count_q >= eff_len_i);
  assign evict_ext    = evict_flag_q ? SUM_W'(evict_q) : '0;
  assign new_sum_o    = sum_q - evict_ext + SUM_W'(sample_q);
  assign new_count_o  = count_q - CNT_W'(evict_flag_q) + CNT_W'(1);

  always_comb begin
    old_ptr_d = old_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    count_d   = count_q;
    sum_d     = sum_q;
    if (ctrl_i.clear || (ctrl_i.update && ctrl_i.last)) begin
      old_ptr_d = '0;
      wr_ptr_d  = '0;
      count_d   = '0;
      sum_d     = '0;
    end else if (ctrl_i.update) begin
      old_ptr_d = evict_flag_q ? advance(old_ptr_q) : old_ptr_q;
      wr_ptr_d  = advance(wr_ptr_q);
      count_d   = new_count_o;
      sum_d     = new_sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_ptr_q    <= '0;
      wr_ptr_q     <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      evict_flag_q <= 1'b0;
    end else begin
      old_ptr_q <= old_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      if (ctrl_i.accept) begin
        evict_flag_q <= evict_flag_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/swma_divider.sv
// Restoring divider, one quotient bit per cycle, with sign applied at the end.
// Depends on swma_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module swma_divider
  import swma_pkg::*;
#(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 9,
  parameter int unsigned RES_W = 24
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  div_ctrl_t               ctrl_i,
  input  wire        [DVD_W-1:0]  dividend_i,
  input  wire        [DVS_W-1:0]  divisor_i,
  input  wire                     neg_i,
  output div_stat_t               stat_o,
  output logic signed [RES_W-1:0] result_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic              busy_q;
  logic              done_q;

  logic [DVS_W:0]    trial;
  logic              fits;
  logic [DVS_W:0]    diff;
  logic [DVD_W-1:0]  signed_quo;

  // Remainder stays below the divisor, so the shifted trial needs one more bit.
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        step_q <= STEP_W'(DVD_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (ctrl_i.ack) begin
        done_q <= 1'b0;
      end
    end
  end

  assign signed_quo    = neg_q ? (DVD_W'(0) - quo_q) : quo_q;
  assign result_o      = signed_quo[RES_W-1:0];
  assign stat_o.busy   = busy_q;
  assign stat_o.done   = done_q;

endmodule

`default_nettype wire

// File: test/tb_sliding_window_moving_average.sv
// Self-checking testbench for the sliding window moving average block.
// Depends on swma_pkg, the channel interfaces and the sliding_window_moving_average top.
`timescale 1ns / 1ps

module tb_sliding_window_moving_average;
  import swma_pkg::*;

  localparam int unsigned WINDOW_SLOTS  = 256;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 12;
  // Long enough for the block to answer an item that it has taken.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // How the two sides of the block idle during a phase of the run.
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_stream;
  } sample_item_t;

  typedef struct packed {
    logic signed [23:0] average;
    logic [8:0]         fill_count;
    logic               last_result;
  } average_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swma_in_if #(.SAMPLE_BITS(16)) in_if ();
  swma_out_if #(.AVERAGE_BITS(24), .FILL_BITS(9)) out_if ();
  swma_cfg_if cfg_if ();

  sliding_window_moving_average dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Samples waiting to be offered, and averages waiting to come out.
  sample_item_t    pending_samples[$];
  average_result_t expected_averages[$];

  idle_mode_e  idle_mode = IDLE_NONE;
  logic        offer_open = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycles_run = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // Our own copy of the window: the ring of samples, its two pointers, the number
  // of samples held and their running sum. The 8-bit pointers wrap by themselves
  // at the 256 slots of the ring.
  logic signed [15:0] ring_samples [WINDOW_SLOTS];
  logic [7:0]         oldest_slot;
  logic [7:0]         next_slot;
  int unsigned        held_samples;
  longint             window_total;
  logic [CFG_W-1:0]   window_length_reg;

  // A length of zero behaves as one, and anything above the ring size as the ring size.
  function automatic int unsigned active_length();
    if (window_length_reg == '0) begin
      return 1;
    end
    if (window_length_reg > WINDOW_SLOTS) begin
      return WINDOW_SLOTS;
    end
    return 32'(window_length_reg);
  endfunction

  task automatic empty_window();
    oldest_slot  = '0;
    next_slot    = '0;
    held_samples = 0;
    window_total = 0;
  endtask

  // Adds one sample to the window and works out the average the block must answer.
  // A full window drops its oldest sample first. The quotient is taken on the
  // magnitude, so it truncates toward zero for negative sums too.
  task automatic fold_in_sample(input sample_item_t item, output average_result_t res);
    longint magnitude;
    longint quotient;
    logic   negative;
    if (held_samples >= active_length()) begin
      window_total -= ring_samples[oldest_slot];
      oldest_slot++;
      held_samples--;
    end
    ring_samples[next_slot] = item.sample;
    next_slot++;
    held_samples++;
    window_total += item.sample;
    negative  = window_total < 0;
    magnitude = negative ? -window_total : window_total;
    quotient  = (magnitude * 256) / longint'(held_samples);
    if (negative) begin
      quotient = -quotient;
    end
    res.average     = quotient[23:0];
    res.fill_count  = held_samples[8:0];
    res.last_result = item.end_of_stream;
    // The end-of-stream item is still averaged; the window empties only after it.
    if (item.end_of_stream) begin
      empty_window();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: average check failed: %s", $time, what);
    error_count++;
  endtask

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: begin
        return $urandom_range(0, 99) < 72;
      end
      IDLE_BOTH: begin
        return $urandom_range(0, 99) < 22;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: begin
        return $urandom_range(0, 99) < 72;
      end
      IDLE_BOTH: begin
        return $urandom_range(0, 99) < 22;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Every input is known from time zero; the processes below take over from here.
  initial begin
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.end_of_stream  = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.window_length = '0;
  end

  // Sample driver. An offer, once made, holds until the block takes it; between
  // offers the payload carries junk so that nothing relies on it while valid is low.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!offer_open) begin
      if (pending_samples.size() != 0 && !sender_idles()) begin
        in_if.sample        <= pending_samples[0].sample;
        in_if.end_of_stream <= pending_samples[0].end_of_stream;
        in_if.valid         <= 1'b1;
        offer_open = 1'b1;
      end else begin
        in_if.sample        <= 16'($urandom);
        in_if.end_of_stream <= 1'($urandom);
        in_if.valid         <= 1'b0;
      end
    end
  end

  // Result receiver. A long hold-off shuts it completely, on top of the random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  // The long hold-off counts its own cycles once the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_requests != holds_served) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
  end

  // Monitor. Results are checked before a new item is folded in; a result can only
  // belong to an item taken long before, so the order within the edge is safe.
  always @(posedge clk) begin : monitor
    average_result_t want;
    average_result_t fresh;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                    out_if.average, out_if.fill_count));
        end else begin
          want = expected_averages.pop_front();
          if (out_if.average !== want.average) begin
            report_mismatch($sformatf("average %0d, predicted %0d",
                                      out_if.average, want.average));
          end
          if (out_if.fill_count !== want.fill_count) begin
            report_mismatch($sformatf("fill_count %0d, predicted %0d",
                                      out_if.fill_count, want.fill_count));
          end
          if (out_if.last_result !== want.last_result) begin
            report_mismatch($sformatf("last_result %b, predicted %b",
                                      out_if.last_result, want.last_result));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        fold_in_sample(pending_samples.pop_front(), fresh);
        expected_averages.push_back(fresh);
        offer_open = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles_run++;
  end

  initial begin : watchdog
    wait (cycles_run >= CYCLE_LIMIT);
    $display("sliding_window_moving_average: mismatch");
    $finish;
  end

  task automatic queue_item(input logic signed [15:0] sample, input logic end_of_stream);
    sample_item_t item;
    item.sample        = sample;
    item.end_of_stream = end_of_stream;
    pending_samples.push_back(item);
  endtask

  // Full-scale values and values near zero come up often, the rest is uniform.
  function automatic logic signed [15:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      return 16'sh7fff;
    end
    if (pick < 24) begin
      return 16'sh8000;
    end
    if (pick < 40) begin
      return 16'(int'($urandom_range(0, 8)) - 4);
    end
    return 16'($urandom);
  endfunction

  task automatic queue_random(input int unsigned count, input int unsigned eos_percent);
    for (int unsigned k = 0; k < count; k++) begin
      queue_item(random_sample(), $urandom_range(0, 99) < eos_percent);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_averages.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The register is only written with the block idle. A write also empties the
  // window, so the model starts a new warm-up as well.
  task automatic write_window_length(input logic [CFG_W-1:0] value);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_if.window_length <= value;
    cfg_if.valid         <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    window_length_reg = value;
    empty_window();
    @(negedge clk);
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= 9'($urandom);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] length, input idle_mode_e mode,
                           input int unsigned count, input int unsigned eos_percent);
    write_window_length(length);
    idle_mode = mode;
    queue_random(count, eos_percent);
    wait_drained();
  endtask

  initial begin : stimulus
    window_length_reg = WINDOW_LENGTH_RESET;
    empty_window();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset length of 8. A window full of the largest
    // positive sample, then one full of the most negative, gives both extremes of
    // the average and walks the eviction through every slot of the window.
    repeat (9) queue_item(16'sh7fff, 1'b0);
    repeat (9) queue_item(16'sh8000, 1'b0);
    queue_item(-16'sd1, 1'b1);
    // A small negative sum over three samples checks truncation toward zero.
    queue_item(-16'sd1, 1'b0);
    queue_item(16'sd0, 1'b0);
    queue_item(16'sd0, 1'b1);
    // Alternating bit patterns, then a stream of a single marked sample.
    queue_item(16'sh5555, 1'b0);
    queue_item(16'shaaaa, 1'b0);
    queue_item(16'sd7, 1'b1);
    queue_item(16'sd123, 1'b1);
    wait_drained();

    // A length of one, then zero, which must behave as one.
    run_phase(9'd1, IDLE_NONE, 16, 10);
    run_phase(9'd0, IDLE_SENDER, 12, 10);

    // Back pressure: the receiver holds off for a long stretch while the sender
    // keeps offering, so the result register fills and the input stalls.
    write_window_length(9'd3);
    idle_mode = IDLE_RECEIVER;
    queue_random(24, 10);
    hold_requests++;
    wait_drained();

    // Lengths above the ring size clip to it.
    run_phase(9'd257, IDLE_BOTH, 16, 3);

    // The all-ones length, with the ring filled by the most negative sample: the
    // sum reaches the bottom of its range and stays there while samples evict.
    // The sender then pauses until every result is in before the stream goes on.
    write_window_length(9'd511);
    idle_mode = IDLE_NONE;
    repeat (262) queue_item(16'sh8000, 1'b0);
    wait_drained();
    idle_mode = IDLE_RECEIVER;
    queue_random(10, 5);
    wait_drained();

    run_phase(9'd2, IDLE_BOTH, 16, 15);
    run_phase(9'd5, IDLE_SENDER, 16, 10);
    run_phase(9'd170, IDLE_RECEIVER, 12, 2);
    run_phase(9'd256, IDLE_BOTH, 12, 5);

    // Let the block settle so that any stray result would still be caught.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_averages.size() == 0) begin
      $display("sliding_window_moving_average: match");
    end else begin
      $display("sliding_window_moving_average: mismatch");
    end
    $finish;
  end

endmodule
